>>> sv/demand_limit_pi_controller_macros.svh
// Assertion macros for the demand-limit PI controller.
`ifndef DEMAND_LIMIT_PI_CONTROLLER_MACROS_SVH
`define DEMAND_LIMIT_PI_CONTROLLER_MACROS_SVH

// Assert that a condition implies a consequence in the same cycle.
`define DLPI_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define DLPI_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dlpi_pkg.sv
// Shared types and constants of the demand-limit PI controller.
`default_nettype none
package dlpi_pkg;

  localparam int unsigned WindowDepth = 1024;
  localparam int unsigned PtrW = $clog2(WindowDepth);
  localparam int unsigned CntW = PtrW + 1;
  localparam int unsigned SumW = 15 + CntW;
  localparam int unsigned IntegW = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] RegWindowLen = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTarget = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPropGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIntegLimit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRampStep = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the item and read the oldest sample
    logic div1_start; // divide old sum by old count
    logic update;     // update window, start second division
    logic mul_p;      // form the proportional product
    logic mul_i;      // form the integral product
    logic finish;     // finish the control law and load the result
    logic fault;      // load the fault result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fault_item;
    logic div_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

>>> sv/demand_limit_pi_controller.sv
// Top level of the demand-limit PI controller.
`default_nettype none
`include "demand_limit_pi_controller_macros.svh"
// One item is taken at a time: the input stays stalled until the item's
// result is loaded and the controller is back in its idle state. Most of
// the work on a valid sample is two passes of the shared restoring divider,
// one for the window average before insertion and one for the average after
// it, each pass one quotient bit a cycle. A fault or negative sample loads
// its result from the check state, once the output register is free. A
// result that is still waiting in the output register holds back only the
// loading of the next one.
module demand_limit_pi_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dlpi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dlpi_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [15:0]            grid_power_i,
  input  wire logic [15:0]                   discharge_limit_i,
  input  wire logic                          discharge_enabled_i,
  input  wire logic                          comm_fault_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [15:0]                        discharge_request_o,
  output logic                               discharging_o,
  output logic                               alarm_o,
  output logic [14:0]                        window_average_o
);
  dlpi_pkg::dp_cmd_t cmd;
  dlpi_pkg::dp_sts_t sts;

  dlpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dlpi_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .grid_power_i        (grid_power_i),
    .discharge_limit_i   (discharge_limit_i),
    .discharge_enabled_i (discharge_enabled_i),
    .comm_fault_i        (comm_fault_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .discharge_request_o (discharge_request_o),
    .discharging_o       (discharging_o),
    .alarm_o             (alarm_o),
    .window_average_o    (window_average_o)
  );

  `DLPI_ASSERT_IMPL(a_disch_flag, clk_i, rst_ni, out_valid_o, discharging_o == (discharge_request_o != '0), "discharging flag disagrees with request")
  `DLPI_ASSERT_NEXT(a_load_stalls, clk_i, rst_ni, cmd.load, in_stall_o, "input not stalled while an item is at work")
  `DLPI_ASSERT_IMPL(a_one_result, clk_i, rst_ni, cmd.finish, !cmd.fault, "two results loaded at once")
endmodule
`default_nettype wire

>>> sv/dlpi_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`default_nettype none
module dlpi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/dlpi_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dlpi_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dlpi_pkg::SumW-1:0]   dividend_i,
  input  wire logic [dlpi_pkg::CntW-1:0]   divisor_i,
  output logic                             busy_o,
  output logic      [dlpi_pkg::SumW-1:0]   quot_o
);
  localparam int unsigned StepW = $clog2(dlpi_pkg::SumW + 1);

  logic [StepW-1:0]            step_q, step_d;
  logic [dlpi_pkg::SumW-1:0]   quot_q, quot_d;
  logic [dlpi_pkg::CntW:0]     rem_q, rem_d;
  logic [dlpi_pkg::CntW-1:0]   dvs_q, dvs_d;
  logic [dlpi_pkg::CntW:0]     trial;

  always_comb begin
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[dlpi_pkg::CntW-1:0], quot_q[dlpi_pkg::SumW-1]};
    if (start_i) begin
      step_d = StepW'(dlpi_pkg::SumW);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = trial - {1'b0, dvs_q};
        quot_d = {quot_q[dlpi_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[dlpi_pkg::SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = (step_q != '0);
  assign quot_o = quot_q;
endmodule
`default_nettype wire

>>> sv/dlpi_datapath.sv
// Datapath: window store, running sum, divider, PI law and result register.
`default_nettype none
module dlpi_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dlpi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dlpi_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic signed [15:0]            grid_power_i,
  input  wire logic [15:0]                   discharge_limit_i,
  input  wire logic                          discharge_enabled_i,
  input  wire logic                          comm_fault_i,
  input  wire dlpi_pkg::dp_cmd_t             cmd_i,
  output dlpi_pkg::dp_sts_t                  sts_o,
  output logic [15:0]                        discharge_request_o,
  output logic                               discharging_o,
  output logic                               alarm_o,
  output logic [14:0]                        window_average_o
);
  localparam int unsigned PtrW = dlpi_pkg::PtrW;
  localparam int unsigned CntW = dlpi_pkg::CntW;
  localparam int unsigned SumW = dlpi_pkg::SumW;
  localparam int unsigned IW = dlpi_pkg::IntegW;

  // Configuration registers.
  logic [10:0] wlen_q;
  logic [14:0] target_q;
  logic [15:0] kp_q, ki_q, ramp_q;
  logic [23:0] ilim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= 11'd60;
      target_q <= 15'd1000;
      kp_q     <= 16'd256;
      ki_q     <= 16'd16;
      ilim_q   <= 24'd1000000;
      ramp_q   <= 16'd100;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dlpi_pkg::RegWindowLen:  wlen_q   <= cfg_data_i[10:0];
        dlpi_pkg::RegTarget:     target_q <= cfg_data_i[14:0];
        dlpi_pkg::RegPropGain:   kp_q     <= cfg_data_i[15:0];
        dlpi_pkg::RegIntegGain:  ki_q     <= cfg_data_i[15:0];
        dlpi_pkg::RegIntegLimit: ilim_q   <= cfg_data_i[23:0];
        dlpi_pkg::RegRampStep:   ramp_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [14:0] p_q;
  logic [15:0] lim_q;
  logic        en_q, flt_q, neg_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q   <= grid_power_i[14:0];
      lim_q <= discharge_limit_i;
      en_q  <= discharge_enabled_i;
      flt_q <= comm_fault_i;
      neg_q <= grid_power_i[15];
    end
  end
  assign sts_o.fault_item = flt_q | neg_q;

  // Window state.
  logic [PtrW-1:0] wp_q;
  logic [CntW-1:0] cnt_q;
  logic [SumW-1:0] sum_q;
  logic [14:0]     last_avg_q;
  logic [IW-1:0]   integ_q;
  logic [15:0]     prev_q;

  logic [CntW-1:0] wlen_eff;
  always_comb begin
    if (wlen_q == '0) begin
      wlen_eff = CntW'(1);
    end else if (CntW'(wlen_q) > CntW'(dlpi_pkg::WindowDepth)) begin
      wlen_eff = CntW'(dlpi_pkg::WindowDepth);
    end else begin
      wlen_eff = CntW'(wlen_q);
    end
  end

  logic            full;
  logic [PtrW-1:0] oldest_addr;
  logic [14:0]     oldest;
  assign full = (cnt_q >= wlen_eff);
  assign oldest_addr = wp_q - cnt_q[PtrW-1:0];

  dlpi_ram #(.Width(15), .Depth(dlpi_pkg::WindowDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (wp_q),
    .wdata_i (p_q),
    .raddr_i (oldest_addr),
    .rdata_o (oldest)
  );

  logic [SumW-1:0] new_sum;
  logic [CntW-1:0] new_cnt;
  assign new_sum = sum_q - (full ? SumW'(oldest) : '0) + SumW'(p_q);
  assign new_cnt = full ? cnt_q : cnt_q + 1'b1;

  // Shared divider.
  logic            div_start, div_busy;
  logic [SumW-1:0] div_q;
  logic [SumW-1:0] div_a;
  logic [CntW-1:0] div_b;
  assign div_start = cmd_i.div1_start | cmd_i.update;
  assign div_a = cmd_i.update ? new_sum : sum_q;
  assign div_b = cmd_i.update ? new_cnt : ((cnt_q == '0) ? CntW'(1) : cnt_q);

  dlpi_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .quot_o     (div_q)
  );
  assign sts_o.div_busy = div_busy;

  // Average before insertion, error and products.
  logic [14:0]        avg_b_q;
  logic signed [16:0] e_q;
  logic signed [33:0] pp_q;
  logic [39:0]        ip_q;
  logic               empty_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      avg_b_q <= empty_q ? 15'd0 : div_q[14:0];
      e_q     <= $signed({2'b00, (empty_q ? 15'd0 : div_q[14:0])})
               - $signed({2'b00, target_q});
    end
    if (cmd_i.div1_start) begin
      empty_q <= (cnt_q == '0);
    end
    if (cmd_i.mul_p) begin
      pp_q <= $signed({1'b0, kp_q}) * e_q;
    end
    if (cmd_i.mul_i) begin
      ip_q <= ki_q * integ_q;
    end
  end

  // Control law.
  logic signed [41:0] acc;
  logic [33:0]        raw;
  logic [15:0]        o_lim, o_ramp;
  logic               sat_hi, sat_lo, active;
  logic signed [25:0] integ_n;
  logic [IW-1:0]      integ_c;
  logic [16:0]        ceil_v;

  always_comb begin
    acc    = 42'(pp_q) + $signed({2'b00, ip_q});
    raw    = acc[41] ? '0 : acc[41:8];
    o_lim  = (raw > 34'(lim_q)) ? lim_q : raw[15:0];
    sat_hi = (o_lim >= lim_q) && (e_q > 0);
    sat_lo = (o_lim == '0) && (e_q < 0);
    integ_n = $signed({2'b00, integ_q});
    if (!sat_hi && !sat_lo) begin
      integ_n = integ_n + 26'(e_q);
    end
    if (integ_n < 0) begin
      integ_c = '0;
    end else if (integ_n > $signed({2'b00, ilim_q})) begin
      integ_c = ilim_q;
    end else begin
      integ_c = integ_n[IW-1:0];
    end
    ceil_v = {1'b0, prev_q} + {1'b0, ramp_q};
    o_ramp = (17'(o_lim) > ceil_v) ? ceil_v[15:0] : o_lim;
    active = en_q && (lim_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      cnt_q      <= '0;
      sum_q      <= '0;
      last_avg_q <= '0;
      integ_q    <= '0;
      prev_q     <= '0;
    end else begin
      if (cmd_i.update) begin
        wp_q  <= wp_q + 1'b1;
        cnt_q <= new_cnt;
        sum_q <= new_sum;
      end
      if (cmd_i.finish) begin
        last_avg_q <= div_q[14:0];
        if (active) begin
          integ_q <= integ_c;
          prev_q  <= o_ramp;
        end else begin
          prev_q <= '0;
        end
      end
      if (cmd_i.fault) begin
        prev_q <= '0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      discharge_request_o <= active ? o_ramp : '0;
      discharging_o       <= active && (o_ramp != '0);
      alarm_o             <= avg_b_q > target_q;
      window_average_o    <= div_q[14:0];
    end else if (cmd_i.fault) begin
      discharge_request_o <= '0;
      discharging_o       <= 1'b0;
      alarm_o             <= flt_q;
      window_average_o    <= last_avg_q;
    end
  end
endmodule
`default_nettype wire

>>> sv/dlpi_ctrl.sv
// Controller state machine and output valid of the demand-limit PI controller.
`default_nettype none
module dlpi_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire dlpi_pkg::dp_sts_t sts_i,
  output dlpi_pkg::dp_cmd_t      cmd_o
);
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StCheck = 7'b0000010,
    StDiv1  = 7'b0000100,
    StUpd   = 7'b0001000,
    StMulP  = 7'b0010000,
    StDiv2  = 7'b0100000,
    StFin   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   in_acc, out_free;

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ov_d    = ov_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (sts_i.fault_item) begin
          if (out_free) begin
            cmd_o.fault = 1'b1;
            ov_d = 1'b1;
            state_d = StIdle;
          end
        end else begin
          cmd_o.div1_start = 1'b1;
          state_d = StDiv1;
        end
      end
      StDiv1: begin
        if (!sts_i.div_busy) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d = StMulP;
      end
      StMulP: begin
        cmd_o.mul_p = 1'b1;
        cmd_o.mul_i = 1'b1;
        state_d = StDiv2;
      end
      StDiv2: begin
        if (!sts_i.div_busy) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

>>> tb/tb_demand_limit_pi_controller.sv
// Self-checking testbench of the demand-limit PI controller with an item predictor.
`timescale 1ns / 1ps

class demand_scoreboard;
  typedef struct {
    bit [15:0] request;
    bit        discharging;
    bit        alarm;
    bit [14:0] average;
  } demand_result_t;

  demand_result_t expected_q[$];
  int errors;

  bit [10:0] win_len;
  bit [14:0] target;
  bit [15:0] kp;
  bit [15:0] ki;
  bit [23:0] integ_max;
  bit [15:0] ramp;

  bit [14:0]   samples[1024];
  int unsigned wptr, count, sum, prev_out, last_avg;
  longint      integ;

  function new();
    win_len = 60; target = 1000; kp = 256; ki = 16; integ_max = 1000000; ramp = 100;
    wptr = 0; count = 0; sum = 0; prev_out = 0; last_avg = 0; integ = 0; errors = 0;
  endfunction

  function void write_reg(bit [2:0] idx, bit [23:0] val);
    case (idx)
      dlpi_pkg::RegWindowLen:  win_len = val[10:0];
      dlpi_pkg::RegTarget:     target = val[14:0];
      dlpi_pkg::RegPropGain:   kp = val[15:0];
      dlpi_pkg::RegIntegGain:  ki = val[15:0];
      dlpi_pkg::RegIntegLimit: integ_max = val;
      dlpi_pkg::RegRampStep:   ramp = val[15:0];
      default: ;
    endcase
  endfunction

  function void note_item(bit signed [15:0] gp, bit [15:0] lim, bit en, bit flt);
    demand_result_t r;
    int unsigned wlen, avg_before, left, o;
    longint e, acc, raw, nxt;
    bit sat_hi, sat_lo;
    if (flt || gp < 0) begin
      prev_out = 0;
      r.request = 0; r.discharging = 0; r.alarm = flt; r.average = last_avg[14:0];
      expected_q.insert(expected_q.size(), r);
      return;
    end
    wlen = (win_len < 1) ? 1 : (win_len > 1024) ? 1024 : win_len;
    avg_before = (count != 0) ? sum / count : 0;
    left = 0;
    // A shortened window evicts only the oldest sample, so the count holds.
    if (count >= wlen) left = samples[(wptr + 1024 - count) % 1024];
    else count++;
    samples[wptr] = gp[14:0];
    wptr = (wptr + 1) % 1024;
    sum = sum - left + int'(gp);
    last_avg = (sum / count) & 32'h7FFF;
    r.alarm = avg_before > target;
    o = 0;
    if (!en || lim == 0) begin
      prev_out = 0;
    end else begin
      e = longint'(avg_before) - longint'(target);
      acc = longint'(kp) * e + longint'(ki) * integ;
      raw = (acc < 0) ? 0 : (acc >>> 8);
      o = (raw > lim) ? lim : int'(raw);
      sat_hi = (o >= lim) && (e > 0);
      sat_lo = (o == 0) && (e < 0);
      nxt = integ;
      if (!sat_hi && !sat_lo) nxt += e;
      if (nxt < 0) nxt = 0;
      if (nxt > longint'(integ_max)) nxt = integ_max;
      integ = nxt;
      if (o > prev_out + ramp) o = prev_out + ramp;
      prev_out = o;
    end
    r.request = o[15:0]; r.discharging = (o > 0); r.average = last_avg[14:0];
    expected_q.insert(expected_q.size(), r);
  endfunction

  function void check_result(bit [15:0] req, bit dis, bit alarm, bit [14:0] avg);
    demand_result_t x;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result req=%0d dis=%0b alarm=%0b avg=%0d",
               $time, req, dis, alarm, avg);
      errors++;
      return;
    end
    x = expected_q[0];
    expected_q.delete(0);
    if (x.request != req) begin
      $display("%0t: discharge_request expected %0d actual %0d", $time, x.request, req);
      errors++;
    end
    if (x.discharging != dis) begin
      $display("%0t: discharging expected %0b actual %0b", $time, x.discharging, dis);
      errors++;
    end
    if (x.alarm != alarm) begin
      $display("%0t: alarm expected %0b actual %0b", $time, x.alarm, alarm);
      errors++;
    end
    if (x.average != avg) begin
      $display("%0t: window_average expected %0d actual %0d", $time, x.average, avg);
      errors++;
    end
  endfunction
endclass

module tb_demand_limit_pi_controller;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dlpi_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [dlpi_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [15:0] grid_power_i = '0;
  logic [15:0] discharge_limit_i = '0;
  logic discharge_enabled_i = 1'b0;
  logic comm_fault_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] discharge_request_o;
  logic discharging_o;
  logic alarm_o;
  logic [14:0] window_average_o;

  demand_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit run_done = 1'b0;

  demand_limit_pi_controller u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(discharge_request_o, discharging_o, alarm_o, window_average_o);
  end

  // Receiver stall pattern: a random hold before each result is taken.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = idle_on ? $urandom_range(0, 11) : 0;
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(logic signed [15:0] gp, logic [15:0] lim, logic en, logic flt);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    grid_power_i <= gp;
    discharge_limit_i <= lim;
    discharge_enabled_i <= en;
    comm_fault_i <= flt;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(gp, lim, en, flt);
  endtask

  // The write enable drops for one cycle between writes.
  task automatic write_reg(logic [dlpi_pkg::CfgIdxW-1:0] idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic random_item();
    int r;
    int tgt;
    logic signed [15:0] gp;
    logic [15:0] lim;
    r = $urandom_range(0, 99);
    tgt = sb.target;
    if (r < 6) gp = 16'(32'd65536 - $urandom_range(1, 32768));
    else if (r < 22) gp = 16'($urandom_range(0, 32767));
    else gp = 16'($urandom_range(tgt / 2, (tgt * 2 > 32767) ? 32767 : tgt * 2));
    r = $urandom_range(0, 99);
    if (r < 5) lim = 16'd0;
    else if (r < 15) lim = 16'hFFFF;
    else lim = 16'($urandom_range(1, 65535));
    send_item(gp, lim, $urandom_range(0, 9) != 0, $urandom_range(0, 11) == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty window, extremes, faults, negative samples, disable paths.
    send_item(16'sd0, 16'd500, 1'b1, 1'b0);
    send_item(16'sd32767, 16'hFFFF, 1'b1, 1'b0);
    send_item(16'sd32767, 16'hFFFF, 1'b1, 1'b0);
    send_item(16'sd32767, 16'd1, 1'b1, 1'b0);
    send_item(-16'sd1, 16'hFFFF, 1'b1, 1'b0);
    send_item(-16'sd32768, 16'hFFFF, 1'b1, 1'b1);
    send_item(16'sd2000, 16'hFFFF, 1'b1, 1'b1);
    send_item(16'sd2000, 16'hFFFF, 1'b0, 1'b0);
    send_item(16'sd2000, 16'd0, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) send_item(16'sd5000, 16'hFFFF, 1'b1, 1'b0);
    for (int i = 0; i < 6; i++) send_item(16'sd0, 16'd3000, 1'b1, 1'b0);
    send_item(16'sd1000, 16'h8000, 1'b1, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1: begin
          write_reg(dlpi_pkg::RegWindowLen, 24'd1);
          write_reg(dlpi_pkg::RegTarget, 24'd1);
          write_reg(dlpi_pkg::RegPropGain, 24'd65535);
          write_reg(dlpi_pkg::RegIntegGain, 24'd65535);
          write_reg(dlpi_pkg::RegIntegLimit, 24'hFFFFFF);
          write_reg(dlpi_pkg::RegRampStep, 24'd65535);
        end
        2: begin
          write_reg(dlpi_pkg::RegWindowLen, 24'd1024);
          write_reg(dlpi_pkg::RegTarget, 24'd32767);
          write_reg(dlpi_pkg::RegPropGain, 24'd1);
          write_reg(dlpi_pkg::RegIntegGain, 24'd1);
          write_reg(dlpi_pkg::RegIntegLimit, 24'd0);
          write_reg(dlpi_pkg::RegRampStep, 24'd0);
        end
        3: begin
          // Shrink the window well below the current sample count.
          write_reg(dlpi_pkg::RegWindowLen, 24'd3);
          write_reg(dlpi_pkg::RegTarget, 24'd3000);
          write_reg(dlpi_pkg::RegPropGain, 24'd512);
          write_reg(dlpi_pkg::RegIntegGain, 24'd40);
          write_reg(dlpi_pkg::RegIntegLimit, 24'd50000);
          write_reg(dlpi_pkg::RegRampStep, 24'd250);
        end
        4: write_reg(dlpi_pkg::RegWindowLen, 24'd0);
        5: write_reg(dlpi_pkg::RegWindowLen, 24'd2047);
        6: begin
          write_reg(dlpi_pkg::RegWindowLen, 24'($urandom_range(2, 40)));
          write_reg(dlpi_pkg::RegTarget, 24'($urandom_range(1, 32767)));
          write_reg(dlpi_pkg::RegPropGain, 24'($urandom_range(1, 65535)));
          write_reg(dlpi_pkg::RegIntegGain, 24'($urandom_range(1, 65535)));
          write_reg(dlpi_pkg::RegIntegLimit, 24'($urandom_range(0, 24'hFFFFFF)));
          write_reg(dlpi_pkg::RegRampStep, 24'($urandom_range(0, 65535)));
        end
        7: begin
          write_reg(dlpi_pkg::RegWindowLen, 24'd60);
          write_reg(dlpi_pkg::RegTarget, 24'd1000);
          write_reg(dlpi_pkg::RegPropGain, 24'd256);
          write_reg(dlpi_pkg::RegIntegGain, 24'd16);
          write_reg(dlpi_pkg::RegIntegLimit, 24'd1000000);
          write_reg(dlpi_pkg::RegRampStep, 24'd100);
        end
        default: ;
      endcase
      for (int i = 0; i < 100; i++) begin
        // Some stretches run back to back on both sides.
        if (i % 25 == 0) idle_on = (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
        random_item();
      end
      drain();
    end
    run_done = 1'b1;
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #6ms;
    if (!run_done) begin
      $display("Regression FAIL");
      $finish;
    end
  end
endmodule
